// File: design/bdq_pkg.sv
// shared types and codes for the bounded deque
package bdq_pkg;

	localparam int WORD_W = 32;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;

	// request codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_DUMP
	} bdq_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic            capture;
		logic            push_front;
		logic            push_back;
		logic            rd_front;
		logic            rd_back;
		logic            rd_dump_first;
		logic            rd_dump_next;
		logic            out_load;
		logic            out_mem;
		logic [ST_W-1:0] out_status;
		logic            out_last;
	} bdq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
		logic dump_last;
		logic out_free;
	} bdq_stat_t;

endpackage

// File: design/bounded_deque_with_dump_unit.sv
// top level of the bounded deque with dump
// Double-ended queue of DEPTH signed 32-bit words kept in a ring memory with
// a registered read port. One request is handled at a time: a push gives its
// result from S_EXEC, a pop from S_POP once its read is back, and a dump of n
// stored words n beats, one per word, from S_DUMP once the first read is
// back; an empty pop or dump and a full push give a single status beat.
// The result register lets the next request be accepted while the last
// result beat is still waiting on m_axis_tready. Op codes five to seven
// are dropped without a result.
module bounded_deque_with_dump_unit import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic signed [WORD_W-1:0] s_axis_tdata,  // [31:0] value
	input  logic [OP_W-1:0]          s_axis_tuser,  // [2:0] op
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic signed [WORD_W-1:0] m_axis_tdata,  // [31:0] value_res
	output logic [ST_W-1:0]          m_axis_tuser,  // [1:0] status
	output logic                     m_axis_tlast
);

	bdq_cmd_t  cmd;
	bdq_stat_t stat;

	// request sequencer
	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage and result beat
	bdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_value   (s_axis_tdata),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (m_axis_tdata),
		.out_status (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule

// File: design/bdq_ctrl.sv
// request sequencer for the bounded deque
module bdq_ctrl import bdq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  bdq_stat_t       stat,
	output bdq_cmd_t        cmd
);

	bdq_state_t      state_q;
	bdq_state_t      state_nxt;
	logic [OP_W-1:0] op_q;
	logic            op_known;
	logic            is_push;
	logic            is_pop;
	logic            is_dump;

	assign op_known = (in_op == OP_PUSH_FRONT) || (in_op == OP_PUSH_BACK)
		|| (in_op == OP_POP_FRONT) || (in_op == OP_POP_BACK) || (in_op == OP_DUMP);
	assign is_push  = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
	assign is_pop   = (op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK);
	assign is_dump  = (op_q == OP_DUMP);
	assign in_ready = (state_q == S_IDLE);

	// state and request code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_PUSH_FRONT;
		end else begin
			state_q <= state_nxt;
			if (in_valid && in_ready) begin
				op_q <= in_op;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && op_known) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (is_pop && !stat.empty) begin
					state_nxt = S_POP;
				end else if (is_dump && !stat.empty) begin
					state_nxt = S_DUMP;
				end else if (stat.out_free) begin
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_EXEC;
				end
			end
			S_POP: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_DUMP: begin
				if (stat.out_free && stat.dump_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd            = '0;
		cmd.out_status = ST_OK;
		cmd.capture    = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: ;
			S_EXEC: begin
				priority if (is_push) begin
					if (stat.out_free) begin
						cmd.out_load   = 1'b1;
						cmd.out_last   = 1'b1;
						cmd.out_status = stat.full ? ST_FULL : ST_OK;
						cmd.push_front = !stat.full && (op_q == OP_PUSH_FRONT);
						cmd.push_back  = !stat.full && (op_q == OP_PUSH_BACK);
					end
				end else if (stat.empty) begin
					if (stat.out_free) begin
						cmd.out_load   = 1'b1;
						cmd.out_last   = 1'b1;
						cmd.out_status = ST_EMPTY;
					end
				end else if (is_pop) begin
					cmd.rd_front = (op_q == OP_POP_FRONT);
					cmd.rd_back  = (op_q == OP_POP_BACK);
				end else begin
					cmd.rd_dump_first = 1'b1;
				end
			end
			S_POP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_mem  = 1'b1;
					cmd.out_last = 1'b1;
				end
			end
			S_DUMP: begin
				if (stat.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_mem      = 1'b1;
					cmd.out_last     = stat.dump_last;
					cmd.rd_dump_next = !stat.dump_last;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: design/bdq_dpath.sv
// ring storage, pointers and result register for the bounded deque
module bdq_dpath import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bdq_cmd_t                 cmd,
	input  logic signed [WORD_W-1:0] in_value,
	output bdq_stat_t                stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] out_value,
	output logic [ST_W-1:0]          out_status,
	output logic                     out_last
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW:0]   DEPTH_S = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] value_q;
	logic signed [WORD_W-1:0] rd_data_q;
	logic [PW-1:0]            front_q;
	logic [CW-1:0]            count_q;
	logic [PW-1:0]            idx_q;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] out_value_q;
	logic [ST_W-1:0]          out_status_q;
	logic                     out_last_q;
	logic [PW-1:0]            front_dec;
	logic [PW-1:0]            front_inc;
	logic [PW-1:0]            count_low;
	logic [PW-1:0]            count_dec;
	logic [PW-1:0]            idx_inc;
	logic [PW-1:0]            wr_addr;
	logic [PW-1:0]            rd_addr;
	logic [PW-1:0]            rd_off;
	logic                     wr_en;
	logic                     rd_en;

	// position of an offset from the front, wrapped once
	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
		input logic [PW-1:0] off);
		logic [PW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[PW-1:0];
	endfunction

	// neighbor positions and offsets
	assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
	assign front_inc = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
	assign count_low = count_q[PW-1:0];
	assign count_dec = count_low - PW'(1);
	assign idx_inc   = idx_q + PW'(1);

	// storage addressing
	assign wr_en   = cmd.push_front || cmd.push_back;
	assign wr_addr = cmd.push_front ? front_dec : ring_add(front_q, count_low);
	assign rd_en   = cmd.rd_front || cmd.rd_back || cmd.rd_dump_first || cmd.rd_dump_next;
	assign rd_off  = cmd.rd_back ? count_dec : (cmd.rd_dump_next ? idx_inc : '0);
	assign rd_addr = ring_add(front_q, rd_off);

	// ring storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q <= in_value;
		end
	end

	// front, fill count and dump cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.rd_front) begin
				front_q <= front_inc;
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rd_front || cmd.rd_back) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.rd_dump_first) begin
				idx_q <= '0;
			end else if (cmd.rd_dump_next) begin
				idx_q <= idx_inc;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= cmd.out_mem ? rd_data_q : '0;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	// status back to the controller
	assign stat.full      = (count_q == DEPTH_C);
	assign stat.empty     = (count_q == '0);
	assign stat.dump_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign stat.out_free  = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("fill count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |-> !stat.full)
		else $error("push into a full ring");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_front || cmd.rd_back || cmd.rd_dump_first) |-> !stat.empty)
		else $error("read from an empty ring");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result register overwritten before taken");

	a_dump_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_dump_next |=> (idx_q == $past(idx_inc)))
		else $error("dump cursor did not advance");
`endif

endmodule

// File: bench/tb.sv
// self-checking stream testbench for the bounded deque with dump
module tb;
	import bdq_pkg::*;

	localparam int RING_DEPTH   = 16;
	localparam int REQ_TARGET   = 430;
	localparam int STALL_CYCLES = 90;
	localparam int TAIL_CYCLES  = 30;
	localparam int MAX_REPORTS  = 10;

	// first of the codes that the block drops without a result
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_DUMP + 3'd1;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [WORD_W-1:0] value;
		bit                       drain_first;
	} request_t;

	typedef struct {
		logic signed [WORD_W-1:0] value;
		logic [ST_W-1:0]          status;
		logic                     last;
	} reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic signed [WORD_W-1:0] s_axis_tdata = '0;  // [31:0] value
	logic [OP_W-1:0]          s_axis_tuser = '0;  // [2:0] op
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic signed [WORD_W-1:0] m_axis_tdata;       // [31:0] value_res
	logic [ST_W-1:0]          m_axis_tuser;       // [1:0] status
	logic                     m_axis_tlast;

	bounded_deque_with_dump_unit #(.DEPTH(RING_DEPTH)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// requests waiting to be sent and results waiting to arrive
	request_t pending[$];
	reply_t   reply_q[$];

	// deque shadow state
	logic signed [WORD_W-1:0] ring_mem [RING_DEPTH];
	int head_pos = 0;
	int fill_cnt = 0;

	// bookkeeping
	int  fault_cnt = 0;
	int  accepted_cnt = 0;
	int  beats_checked = 0;
	int  op_seen [8] = '{default: 0};
	int  full_hits = 0;
	int  empty_hits = 0;
	int  queued_real = 0;
	bit  offer_live = 1'b0;
	logic hold_off = 1'b0;

	// one stretch where neither side idles
	wire quiet_run = (accepted_cnt >= 250) && (accepted_cnt < 330);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
	end

	task automatic note_fault(input string what);
		fault_cnt++;
		if (fault_cnt <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// work out the result beats of one accepted request
	task automatic deque_apply(input request_t rq);
		reply_t r;
		int     slot;
		r = '{value: '0, status: ST_OK, last: 1'b1};
		op_seen[rq.op]++;
		case (rq.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (fill_cnt == RING_DEPTH) begin
					r.status = ST_FULL;
					full_hits++;
				end else begin
					if (rq.op == OP_PUSH_FRONT) begin
						head_pos = (head_pos + RING_DEPTH - 1) % RING_DEPTH;
						ring_mem[head_pos] = rq.value;
					end else begin
						ring_mem[(head_pos + fill_cnt) % RING_DEPTH] = rq.value;
					end
					fill_cnt++;
				end
				reply_q.push_back(r);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (fill_cnt == 0) begin
					r.status = ST_EMPTY;
					empty_hits++;
				end else begin
					if (rq.op == OP_POP_FRONT) begin
						slot = head_pos;
						head_pos = (head_pos + 1) % RING_DEPTH;
					end else begin
						slot = (head_pos + fill_cnt - 1) % RING_DEPTH;
					end
					fill_cnt--;
					r.value = ring_mem[slot];
				end
				reply_q.push_back(r);
			end
			OP_DUMP: begin
				if (fill_cnt == 0) begin
					r.status = ST_EMPTY;
					empty_hits++;
					reply_q.push_back(r);
				end else begin
					for (int i = 0; i < fill_cnt; i++) begin
						r.value = ring_mem[(head_pos + i) % RING_DEPTH];
						r.last  = (i == fill_cnt - 1);
						reply_q.push_back(r);
					end
				end
			end
			default: ;  // dropped code, nothing comes back
		endcase
	endtask

	// accept detection, prediction and result checking
	always @(posedge clk) begin : monitor
		reply_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				deque_apply(pending[0]);
				pending.pop_front();
				offer_live = 1'b0;
				accepted_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				beats_checked++;
				if (reply_q.size() == 0) begin
					note_fault($sformatf("unexpected beat value=%0d status=%0d last=%0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want = reply_q.pop_front();
					if (m_axis_tdata !== want.value || m_axis_tuser !== want.status ||
						m_axis_tlast !== want.last)
						note_fault($sformatf(
							"exp value=%0d status=%0d last=%0b, got value=%0d status=%0d last=%0b",
							want.value, want.status, want.last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end
			end
		end
	end

	// request driver, holds each beat until it is taken
	always @(negedge clk) begin : driver
		bit idle_now;
		idle_now = !quiet_run && ($urandom_range(99) < 11);
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!offer_live) begin
			if (pending.size() != 0 && !idle_now &&
				!(pending[0].drain_first && reply_q.size() != 0)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending[0].value;
				s_axis_tuser  <= pending[0].op;
				offer_live = 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver with random back-pressure
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			m_axis_tready <= 1'b0;
		else if (quiet_run)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(99) >= 11);
	end

	// long receiver stall so the block backs up into its input
	initial begin
		wait (accepted_cnt >= 120);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#8000000;
		$display("bounded_deque_with_dump_unit verification failed");
		$finish;
	end

	task automatic queue_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
		input bit drain);
		request_t rq;
		rq = '{op: op, value: value, drain_first: drain};
		pending.push_back(rq);
		if (op <= OP_DUMP)
			queued_real++;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// stimulus and end of run
	initial begin : stimulus
		int pick;
		int burst;

		// empty queue corners
		queue_request(OP_DUMP, '0, 1'b0);
		queue_request(OP_POP_FRONT, 32'h5a5a_5a5a, 1'b0);
		queue_request(OP_POP_BACK, '1, 1'b0);
		// extremes pushed at both ends
		queue_request(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
		queue_request(OP_PUSH_BACK, 32'h7fff_ffff, 1'b0);
		queue_request(OP_PUSH_FRONT, '1, 1'b0);
		queue_request(OP_PUSH_BACK, '0, 1'b0);
		queue_request(OP_DUMP, 32'h1234_5678, 1'b0);
		queue_request(OP_POP_FRONT, '0, 1'b0);
		queue_request(OP_POP_BACK, '0, 1'b0);
		// dropped codes
		queue_request(OP_UNUSED_FIRST, 32'hdead_beef, 1'b0);
		queue_request(OP_UNUSED_FIRST + 3'd1, '0, 1'b0);
		queue_request(OP_UNUSED_FIRST + 3'd2, '1, 1'b0);
		queue_request(OP_DUMP, '0, 1'b0);
		queue_request(OP_POP_BACK, '0, 1'b0);
		// removing the only element, then popping empty
		queue_request(OP_POP_FRONT, '0, 1'b0);
		queue_request(OP_POP_FRONT, '0, 1'b0);
		queue_request(OP_DUMP, '0, 1'b0);

		// sender waits for a full drain before the random part
		queue_request(OP_PUSH_BACK, $urandom, 1'b1);

		while (queued_real < REQ_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// fill past full, dump, then drain past empty
				burst = RING_DEPTH + 1 + $urandom_range(2);
				repeat (burst)
					queue_request($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
						pick_word(), 1'b0);
				queue_request(OP_DUMP, $urandom, 1'b0);
				repeat (burst)
					queue_request($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT,
						$urandom, 1'b0);
				queue_request(OP_DUMP, $urandom, 1'b0);
			end else if (pick < 11) begin
				queue_request(OP_UNUSED_FIRST + 3'($urandom_range(2)), $urandom, 1'b0);
			end else if (pick < 13) begin
				queue_request(3'($urandom_range(4)), pick_word(), 1'b1);
			end else if (pick < 55) begin
				queue_request($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
					pick_word(), 1'b0);
			end else if (pick < 85) begin
				queue_request($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT,
					$urandom, 1'b0);
			end else begin
				queue_request(OP_DUMP, $urandom, 1'b0);
			end
		end

		while (pending.size() != 0 || reply_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests taken: %0d push (%0d full), %0d pop, %0d dump, %0d dropped",
			accepted_cnt, op_seen[OP_PUSH_FRONT] + op_seen[OP_PUSH_BACK], full_hits,
			op_seen[OP_POP_FRONT] + op_seen[OP_POP_BACK], op_seen[OP_DUMP],
			accepted_cnt - queued_real);
		$display("%0d result beats checked, %0d empty reports, %0d mismatches",
			beats_checked, empty_hits, fault_cnt);
		if (fault_cnt == 0)
			$display("bounded_deque_with_dump_unit verification clean");
		else
			$display("bounded_deque_with_dump_unit verification failed");
		$finish;
	end

endmodule
